@@ rtl/fbp_pkg.sv @@
package fbp_pkg;

	// field widths
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned ID_W   = 64;
	localparam int unsigned SEQ_W  = 32;

	// frame layout
	localparam logic [BYTE_W-1:0] ID_BYTES      = 8'd8;
	localparam logic [BYTE_W-1:0] SEQ_BYTES     = 8'd4;
	localparam logic [BYTE_W-1:0] HEADER_BYTES  = 8'd16;
	localparam logic [BYTE_W-1:0] VERSION_RESET = 8'd1;

	// parser phase, one-hot
	typedef enum logic [6:0] {
		PH_VER  = 7'b0000001,
		PH_CMD  = 7'b0000010,
		PH_LEN  = 7'b0000100,
		PH_TYPE = 7'b0001000,
		PH_ID   = 7'b0010000,
		PH_SEQ  = 7'b0100000,
		PH_PL   = 7'b1000000
	} phase_t;

endpackage

@@ rtl/fbp_rx_if.sv @@
interface fbp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

@@ rtl/fbp_res_if.sv @@
interface fbp_res_if;
	logic        valid;
	logic        ready;
	logic [7:0]  payload_byte;
	logic        payload_valid;
	logic        frame_done;
	logic [7:0]  frame_command;
	logic [7:0]  frame_length;
	logic [7:0]  frame_dev_kind;
	logic [63:0] frame_dev_id;
	logic [31:0] frame_seq;

	modport source (
		output valid, output payload_byte, output payload_valid, output frame_done,
		output frame_command, output frame_length, output frame_dev_kind,
		output frame_dev_id, output frame_seq, input ready
	);
	modport sink (
		input valid, input payload_byte, input payload_valid, input frame_done,
		input frame_command, input frame_length, input frame_dev_kind,
		input frame_dev_id, input frame_seq, output ready
	);
endinterface

@@ rtl/frame_header_byte_parser.sv @@
// channel | dir | payload                                    | request
// rx      | in  | rx_byte                                    | one received byte
// res     | out | payload byte/valid, frame_done, header set | payload byte or frame end
// cfg     | in  | cfg_we, cfg_wdata                          | version byte write
//
// One byte is taken per cycle unless a stalled result holds the input off; its result
// shows in the result register the next cycle. A byte is taken whenever the result
// register is empty or being drained now; bytes without a result still need that slot.
// Reset clears the phase to hunting, the header fields to zero and the version to 1.
module frame_header_byte_parser (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [fbp_pkg::BYTE_W-1:0] cfg_wdata,
	fbp_rx_if.sink                   rx,
	fbp_res_if.source                res
);
	import fbp_pkg::*;

	phase_t            phase_q, phase_d;
	logic [BYTE_W-1:0] version_q;
	logic [BYTE_W-1:0] count_q, count_d, count_inc;
	logic [BYTE_W-1:0] cmd_q, cmd_d;
	logic [BYTE_W-1:0] len_q, len_d;
	logic [BYTE_W-1:0] type_q, type_d;
	logic [ID_W-1:0]   id_q, id_d;
	logic [SEQ_W-1:0]  seq_q, seq_d;

	logic              emit;
	logic              pvalid;
	logic              done;
	logic [BYTE_W-1:0] pbyte;
	logic              accept;
	logic              out_valid_q;

	assign rx.ready = !out_valid_q || res.ready;
	assign accept   = rx.valid && rx.ready;
	assign count_inc = count_q + 8'd1;

	// next state and result for the byte at the input
	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		cmd_d   = cmd_q;
		len_d   = len_q;
		type_d  = type_q;
		id_d    = id_q;
		seq_d   = seq_q;
		emit    = 1'b0;
		pvalid  = 1'b0;
		done    = 1'b0;
		pbyte   = '0;
		unique case (phase_q)
			PH_CMD: begin
				cmd_d   = rx.rx_byte;
				phase_d = PH_LEN;
			end
			PH_LEN: begin
				len_d   = rx.rx_byte;
				phase_d = PH_TYPE;
			end
			PH_TYPE: begin
				type_d  = rx.rx_byte;
				count_d = '0;
				phase_d = PH_ID;
			end
			PH_ID: begin
				id_d    = {id_q[ID_W-BYTE_W-1:0], rx.rx_byte};
				count_d = count_inc;
				if (count_inc >= ID_BYTES) begin
					count_d = '0;
					phase_d = PH_SEQ;
				end
			end
			PH_SEQ: begin
				seq_d   = {seq_q[SEQ_W-BYTE_W-1:0], rx.rx_byte};
				count_d = count_inc;
				if (count_inc >= SEQ_BYTES) begin
					count_d = '0;
					// no payload: the last sequence byte ends the frame
					if (len_q <= HEADER_BYTES) begin
						phase_d = PH_VER;
						emit    = 1'b1;
						done    = 1'b1;
					end else begin
						phase_d = PH_PL;
					end
				end
			end
			PH_PL: begin
				count_d = count_inc;
				done    = (count_inc >= (len_q - HEADER_BYTES));
				if (done) begin
					phase_d = PH_VER;
					count_d = '0;
				end
				emit   = 1'b1;
				pvalid = 1'b1;
				pbyte  = rx.rx_byte;
			end
			default: begin
				// hunting; a match opens a frame with cleared header
				if (rx.rx_byte == version_q) begin
					cmd_d   = '0;
					len_d   = '0;
					type_d  = '0;
					id_d    = '0;
					seq_d   = '0;
					count_d = '0;
					phase_d = PH_CMD;
				end else begin
					phase_d = PH_VER;
				end
			end
		endcase
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_VER;
			count_q <= '0;
			cmd_q   <= '0;
			len_q   <= '0;
			type_q  <= '0;
			id_q    <= '0;
			seq_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			count_q <= count_d;
			cmd_q   <= cmd_d;
			len_q   <= len_d;
			type_q  <= type_d;
			id_q    <= id_d;
			seq_q   <= seq_d;
		end
	end

	// version register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_q <= VERSION_RESET;
		end else if (cfg_we) begin
			version_q <= cfg_wdata;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= emit;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept && emit) begin
			res.payload_byte   <= pbyte;
			res.payload_valid  <= pvalid;
			res.frame_done     <= done;
			res.frame_command  <= cmd_d;
			res.frame_length   <= len_d;
			res.frame_dev_kind <= type_d;
			res.frame_dev_id   <= id_d;
			res.frame_seq      <= seq_d;
		end
	end

	assign res.valid = out_valid_q;

endmodule

@@ rtl/fbp_checker.sv @@
module fbp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rx_valid,
	input logic       rx_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic [7:0] payload_byte,
	input logic       payload_valid,
	input logic       frame_done
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(payload_byte)
			&& $stable(payload_valid) && $stable(frame_done))
		else $error("stalled result changed");

	// every result is a payload byte or a frame end
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> payload_valid || frame_done)
		else $error("empty result");

	// a result without payload carries a zero byte
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !payload_valid |-> payload_byte == 8'd0)
		else $error("payload byte set without payload");

	// a fresh result follows an accepted byte
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(rx_valid && rx_ready))
		else $error("result without request");

	// an empty result slot never holds off the input
	assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> rx_ready)
		else $error("input stalled while result slot empty");

endmodule

bind frame_header_byte_parser fbp_checker u_fbp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rx_valid      (rx.valid),
	.rx_ready      (rx.ready),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.payload_byte  (res.payload_byte),
	.payload_valid (res.payload_valid),
	.frame_done    (res.frame_done)
);
